// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define AHK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/ahk_pkg.sv -----
`timescale 1ns / 1ps

package ahk_pkg;

    localparam int ESCAPE_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] ASCII_ESC      = 8'h1b;
    localparam logic [7:0] ASCII_LBRACKET = 8'h5b;

    localparam logic [7:0] USAGE_NONE   = 8'h00;
    localparam logic [7:0] USAGE_ESCAPE = 8'h29;
    localparam logic [7:0] USAGE_UP     = 8'h52;
    localparam logic [7:0] USAGE_DOWN   = 8'h51;
    localparam logic [7:0] USAGE_RIGHT  = 8'h4f;
    localparam logic [7:0] USAGE_LEFT   = 8'h50;

    localparam logic [7:0] SHIFT_BIT = 8'h02;

    typedef struct packed {
        logic [7:0] code;
        logic       shift;
    } key_cmd_t;

    typedef enum logic {
        ST_PRESS,
        ST_RELEASE
    } back_state_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] r;
        r = USAGE_NONE;
        if ((c >= 8'h61) && (c <= 8'h7a))
        begin
            r = 8'h04 + (c - 8'h61);
        end
        else if (is_upper(c))
        begin
            r = 8'h04 + (c - 8'h41);
        end
        else if ((c >= 8'h31) && (c <= 8'h39))
        begin
            r = 8'h1e + (c - 8'h31);
        end
        else
        begin
            case (c)
                8'h30:   r = 8'h27;
                8'h20:   r = 8'h2c;
                8'h0a:   r = 8'h28;
                8'h0d:   r = 8'h28;
                8'h08:   r = 8'h2a;
                8'h09:   r = 8'h2b;
                8'h1b:   r = USAGE_ESCAPE;
                8'h21:   r = 8'h1e;
                8'h40:   r = 8'h1f;
                8'h23:   r = 8'h20;
                8'h24:   r = 8'h21;
                8'h25:   r = 8'h22;
                8'h5e:   r = 8'h23;
                8'h26:   r = 8'h24;
                8'h2a:   r = 8'h25;
                8'h28:   r = 8'h26;
                8'h29:   r = 8'h27;
                8'h2d:   r = 8'h2d;
                8'h3d:   r = 8'h2e;
                8'h5b:   r = 8'h2f;
                8'h5d:   r = 8'h30;
                8'h5c:   r = 8'h31;
                8'h3b:   r = 8'h33;
                8'h27:   r = 8'h34;
                8'h60:   r = 8'h35;
                8'h2c:   r = 8'h36;
                8'h2e:   r = 8'h37;
                8'h2f:   r = 8'h38;
                default: r = USAGE_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic logic [7:0] arrow_code(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h41:   r = USAGE_UP;
            8'h42:   r = USAGE_DOWN;
            8'h43:   r = USAGE_RIGHT;
            8'h44:   r = USAGE_LEFT;
            default: r = USAGE_NONE;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/ahk_channels.sv -----
`timescale 1ns / 1ps

interface ahk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       next_is_bracket;

    modport source (output valid, output char_byte, output next_is_bracket, input ready);
    modport sink   (input valid, input char_byte, input next_is_bracket, output ready);
endinterface

interface ahk_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifiers;
    logic [7:0] key_slot_one;
    logic [7:0] key_slot_two;
    logic [7:0] key_slot_three;
    logic [7:0] key_slot_four;
    logic [7:0] key_slot_five;
    logic [7:0] key_slot_six;
    logic       is_release;
    logic       last;

    modport source (output valid, output modifiers, output key_slot_one, output key_slot_two,
                    output key_slot_three, output key_slot_four, output key_slot_five,
                    output key_slot_six, output is_release, output last, input ready);
    modport sink   (input valid, input modifiers, input key_slot_one, input key_slot_two,
                    input key_slot_three, input key_slot_four, input key_slot_five,
                    input key_slot_six, input is_release, input last, output ready);
endinterface

// ----- sv/ahk_front.sv -----
`timescale 1ns / 1ps

module ahk_front #(
    parameter int ESCAPE_DEPTH = ahk_pkg::ESCAPE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ahk_byte_if.sink          byte_chan,
    output ahk_pkg::key_cmd_t cmd,
    output logic              push,
    input  logic              full
);
    import ahk_pkg::*;

    localparam int            CW        = $clog2(ESCAPE_DEPTH);
    localparam logic [CW-1:0] CAP_LIMIT = CW'(ESCAPE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_ONE   = CW'(1);
    localparam logic [CW-1:0] CNT_TWO   = CW'(2);

    logic [CW-1:0] count_reg, count_next;
    logic          bracket_reg, bracket_next;
    logic [7:0]    c;
    logic [7:0]    code;
    logic [7:0]    arrow;
    logic          take;

    assign c               = byte_chan.char_byte;
    assign take            = byte_chan.valid && !full;
    assign byte_chan.ready = !full;
    assign arrow           = arrow_code(c);

    always_comb
    begin
        count_next   = count_reg;
        bracket_next = bracket_reg;
        code         = USAGE_NONE;
        if (count_reg != '0)
        begin
            // capture running: count to the limit or an arrow, then drop it
            if (count_reg < CAP_LIMIT)
            begin
                count_next = count_reg + CNT_ONE;
                if (count_reg == CNT_ONE)
                begin
                    bracket_next = (c == ASCII_LBRACKET);
                end
            end
            else
            begin
                count_next = '0;
            end
            if ((count_reg == CNT_TWO) && bracket_reg && (arrow != USAGE_NONE))
            begin
                code       = arrow;
                count_next = '0;
            end
        end
        else if (c == ASCII_ESC)
        begin
            if (byte_chan.next_is_bracket)
            begin
                count_next = CNT_ONE;
            end
            else
            begin
                code = USAGE_ESCAPE;
            end
        end
        else
        begin
            code = map_char(c);
        end
    end

    assign push      = take && (code != USAGE_NONE);
    assign cmd.code  = code;
    assign cmd.shift = is_upper(c) && (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            bracket_reg <= 1'b0;
        end
        else if (take)
        begin
            count_reg   <= count_next;
            bracket_reg <= bracket_next;
        end
    end

endmodule

// ----- sv/ahk_queue.sv -----
`timescale 1ns / 1ps

module ahk_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ahk_pkg::key_cmd_t wr_data,
    input  logic              push,
    output logic              full,
    output ahk_pkg::key_cmd_t rd_data,
    output logic              nonempty,
    input  logic              pop
);
    import ahk_pkg::*;

    localparam int            PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int            NW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] DEPTH = NW'(QUEUE_DEPTH);

    key_cmd_t      entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == DEPTH);
    assign nonempty = (fill_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

// ----- sv/ahk_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ahk_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ahk_pkg::key_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              pop,
    ahk_report_if.source      report_chan
);
    import ahk_pkg::*;

    back_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  key_reg;
    logic        shift_reg;
    logic        rel_reg;
    logic        load;
    logic        load_press;
    logic        load_release;

    // output register is free when empty or being taken this cycle
    assign load = !out_valid_reg || report_chan.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_PRESS:
            begin
                if (load && cmd_valid)
                begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE:
            begin
                if (load)
                begin
                    state_next = ST_PRESS;
                end
            end
            default: state_next = ST_PRESS;
        endcase
    end

    always_comb
    begin
        load_press   = 1'b0;
        load_release = 1'b0;
        case (state_reg)
            ST_PRESS:   load_press   = load && cmd_valid;
            ST_RELEASE: load_release = load;
            default:
            begin
                load_press   = 1'b0;
                load_release = 1'b0;
            end
        endcase
    end

    assign pop = load_press;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_press || load_release)
        begin
            out_valid_next = 1'b1;
        end
        else if (report_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PRESS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_press)
        begin
            key_reg   <= cmd.code;
            shift_reg <= cmd.shift;
            rel_reg   <= 1'b0;
        end
        else if (load_release)
        begin
            key_reg   <= USAGE_NONE;
            shift_reg <= 1'b0;
            rel_reg   <= 1'b1;
        end
    end

    assign report_chan.valid          = out_valid_reg;
    assign report_chan.modifiers      = shift_reg ? SHIFT_BIT : 8'h00;
    assign report_chan.key_slot_one   = key_reg;
    assign report_chan.key_slot_two   = USAGE_NONE;
    assign report_chan.key_slot_three = USAGE_NONE;
    assign report_chan.key_slot_four  = USAGE_NONE;
    assign report_chan.key_slot_five  = USAGE_NONE;
    assign report_chan.key_slot_six   = USAGE_NONE;
    assign report_chan.is_release     = rel_reg;
    assign report_chan.last           = rel_reg;

    `AHK_ASSERT_IMPL(a_release_pending_behind_press, clk, rst_n, state_reg == ST_RELEASE, out_valid_reg && !rel_reg)
    `AHK_ASSERT_NEXT(a_release_follows_press, clk, rst_n, report_chan.valid && report_chan.ready && !report_chan.is_release, report_chan.valid && report_chan.is_release)
    `AHK_ASSERT_IMPL(a_release_empty, clk, rst_n, out_valid_reg && rel_reg, key_reg == USAGE_NONE && !shift_reg)
    `AHK_ASSERT_IMPL(a_no_pop_in_release, clk, rst_n, state_reg == ST_RELEASE, !pop)

endmodule

// ----- sv/ascii_to_hid_keyboard_report.sv -----
`timescale 1ns / 1ps
// A byte accepted by the front that maps to a key code is written into the queue,
// then loaded into the output register as its press report. The back stage sends
// the press and release reports through one output register; the front takes bytes
// whenever the queue is not full. Reset (rst_n low, asynchronous) clears the escape
// capture, the queue pointers and the output valid; no clearing pass is needed.
module ascii_to_hid_keyboard_report #(
    parameter int ESCAPE_DEPTH = ahk_pkg::ESCAPE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ahk_byte_if.sink     byte_chan,
    ahk_report_if.source report_chan
);
    import ahk_pkg::*;

    key_cmd_t front_cmd;
    key_cmd_t queue_cmd;
    logic     push;
    logic     full;
    logic     nonempty;
    logic     pop;

    ahk_front #(
        .ESCAPE_DEPTH (ESCAPE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .cmd       (front_cmd),
        .push      (push),
        .full      (full)
    );

    ahk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_cmd),
        .push     (push),
        .full     (full),
        .rd_data  (queue_cmd),
        .nonempty (nonempty),
        .pop      (pop)
    );

    ahk_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (queue_cmd),
        .cmd_valid   (nonempty),
        .pop         (pop),
        .report_chan (report_chan)
    );

endmodule

// ----- sim/ascii_to_hid_keyboard_report_test.sv -----
`timescale 1ns / 1ps

module ascii_to_hid_keyboard_report_test;
    import ahk_pkg::*;

    localparam int HOLD_LIMIT = ESCAPE_DEPTH_DEF - 1;
    localparam int SLOTS      = 6;

    typedef struct packed {
        logic [7:0]            modifiers;
        logic [SLOTS-1:0][7:0] slot;
        logic                  is_release;
        logic                  last;
    } hid_report_t;

    logic clk = 1'b0;
    logic rst_n;

    ahk_byte_if   byte_if ();
    ahk_report_if report_if ();

    ascii_to_hid_keyboard_report DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_if),
        .report_chan (report_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // keyboard state as seen by the predictor
    int         esc_held;
    logic [7:0] esc_seq [3];
    logic [7:0] down_keys [SLOTS];
    int         down_count;
    logic [7:0] shift_mods;

    hid_report_t expected_reports [$];
    int          mismatch_count;
    int          items_sent;
    int          send_idle_pct;
    int          recv_stall_pct;

    function automatic logic [7:0] usage_of(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            return 8'h04 + (c - 8'h61);
        end
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            return 8'h04 + (c - 8'h41);
        end
        if (c >= 8'h31 && c <= 8'h39)
        begin
            return 8'h1e + (c - 8'h31);
        end
        case (c)
            8'h30, 8'h29: return 8'h27;
            8'h20:        return 8'h2c;
            8'h0a, 8'h0d: return 8'h28;
            8'h08:        return 8'h2a;
            8'h09:        return 8'h2b;
            ASCII_ESC:    return USAGE_ESCAPE;
            8'h21:        return 8'h1e;
            8'h40:        return 8'h1f;
            8'h23:        return 8'h20;
            8'h24:        return 8'h21;
            8'h25:        return 8'h22;
            8'h5e:        return 8'h23;
            8'h26:        return 8'h24;
            8'h2a:        return 8'h25;
            8'h28:        return 8'h26;
            8'h2d:        return 8'h2d;
            8'h3d:        return 8'h2e;
            8'h5b:        return 8'h2f;
            8'h5d:        return 8'h30;
            8'h5c:        return 8'h31;
            8'h3b:        return 8'h33;
            8'h27:        return 8'h34;
            8'h60:        return 8'h35;
            8'h2c:        return 8'h36;
            8'h2e:        return 8'h37;
            8'h2f:        return 8'h38;
            default:      return USAGE_NONE;
        endcase
    endfunction

    function automatic logic [7:0] arrow_usage(input logic [7:0] c);
        case (c)
            8'h41:   return USAGE_UP;
            8'h42:   return USAGE_DOWN;
            8'h43:   return USAGE_RIGHT;
            8'h44:   return USAGE_LEFT;
            default: return USAGE_NONE;
        endcase
    endfunction

    function automatic hid_report_t keyboard_snapshot(input logic rel);
        hid_report_t r;
        r.modifiers = shift_mods;
        for (int i = 0; i < SLOTS; i++)
        begin
            r.slot[i] = (i < down_count) ? down_keys[i] : USAGE_NONE;
        end
        r.is_release = rel;
        r.last       = rel;
        return r;
    endfunction

    // Advance the keyboard state by one byte and queue the reports it causes.
    function automatic void predict_keystroke(input logic [7:0] c, input logic bracket_next);
        logic [7:0] code;
        logic       from_arrow;
        logic       shifted;
        int         hit;
        code       = USAGE_NONE;
        from_arrow = 1'b0;
        if (esc_held != 0)
        begin
            if (esc_held < HOLD_LIMIT)
            begin
                if (esc_held < 3)
                begin
                    esc_seq[esc_held] = c;
                end
                esc_held++;
            end
            else
            begin
                esc_held = 0;
            end
            if (esc_held >= 3 && esc_seq[0] == ASCII_ESC && esc_seq[1] == ASCII_LBRACKET)
            begin
                code = arrow_usage(esc_seq[2]);
                if (code != USAGE_NONE)
                begin
                    esc_held   = 0;
                    from_arrow = 1'b1;
                end
            end
        end
        else if (c == ASCII_ESC && bracket_next)
        begin
            esc_seq[0] = c;
            esc_held   = 1;
        end
        else
        begin
            code = usage_of(c);
        end
        if (code == USAGE_NONE)
        begin
            return;
        end

        shifted = (c >= 8'h41 && c <= 8'h5a) && !from_arrow;
        if (shifted)
        begin
            shift_mods = shift_mods | SHIFT_BIT;
        end

        hit = -1;
        for (int i = 0; i < down_count; i++)
        begin
            if (down_keys[i] == code)
            begin
                hit = i;
            end
        end
        if (down_count < SLOTS && hit < 0)
        begin
            down_keys[down_count] = code;
            down_count++;
        end
        expected_reports.push_back(keyboard_snapshot(1'b0));

        hit = -1;
        for (int i = down_count - 1; i >= 0; i--)
        begin
            if (down_keys[i] == code)
            begin
                hit = i;
            end
        end
        if (hit >= 0)
        begin
            for (int j = hit; j + 1 < down_count; j++)
            begin
                down_keys[j] = down_keys[j + 1];
            end
            down_count--;
            down_keys[down_count] = USAGE_NONE;
        end
        if (shifted)
        begin
            shift_mods = shift_mods & ~SHIFT_BIT;
        end
        expected_reports.push_back(keyboard_snapshot(1'b1));
    endfunction

    // Hold valid across back-to-back transactions; drop it only while the sender idles.
    task automatic send_byte(input logic [7:0] c, input logic bracket_next);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid           <= 1'b1;
        byte_if.char_byte       <= c;
        byte_if.next_is_bracket <= bracket_next;
        @(posedge clk);
        while (!byte_if.ready)
        begin
            @(posedge clk);
        end
        predict_keystroke(c, bracket_next);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        report_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : report_check
        hid_report_t want;
        hid_report_t got;
        string       slot_names [SLOTS];
        slot_names = '{"key_slot_one", "key_slot_two", "key_slot_three",
                       "key_slot_four", "key_slot_five", "key_slot_six"};
        if (rst_n && report_if.valid && report_if.ready)
        begin
            got.modifiers  = report_if.modifiers;
            got.slot[0]    = report_if.key_slot_one;
            got.slot[1]    = report_if.key_slot_two;
            got.slot[2]    = report_if.key_slot_three;
            got.slot[3]    = report_if.key_slot_four;
            got.slot[4]    = report_if.key_slot_five;
            got.slot[5]    = report_if.key_slot_six;
            got.is_release = report_if.is_release;
            got.last       = report_if.last;
            if (expected_reports.size() == 0)
            begin
                $error("unexpected report: modifiers %h key_slot_one %h is_release %b",
                       got.modifiers, got.slot[0], got.is_release);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("modifiers", want.modifiers, got.modifiers);
                for (int i = 0; i < SLOTS; i++)
                begin
                    check_field(slot_names[i], want.slot[i], got.slot[i]);
                end
                check_field("is_release", {7'd0, want.is_release}, {7'd0, got.is_release});
                check_field("last", {7'd0, want.last}, {7'd0, got.last});
            end
        end
    end

    task automatic test_plain_keys();
        logic [7:0] key_list [12];
        key_list = '{8'h61, 8'h7a, 8'h41, 8'h5a, 8'h30, 8'h39,
                     8'h20, 8'h0d, 8'h08, 8'h09, 8'h00, 8'hff};
        foreach (key_list[i])
        begin
            send_byte(key_list[i], i[0]);
        end
    endtask

    task automatic test_escape_handling();
        logic [7:0] runaway [7];
        runaway = '{8'h42, 8'h61, 8'h31, 8'h20, 8'h78, 8'h7a, 8'h6b};
        send_byte(ASCII_ESC, 1'b0);
        send_byte(ASCII_ESC, 1'b1);
        send_byte(ASCII_LBRACKET, 1'b0);
        send_byte(8'h41, 1'b0);
        // broken sequence: held until the capture overflows, then typing resumes
        send_byte(ASCII_ESC, 1'b1);
        send_byte(8'h51, 1'b0);
        foreach (runaway[i])
        begin
            send_byte(runaway[i], 1'b0);
        end
        send_byte(8'h6b, 1'b0);
    endtask

    task automatic test_random_typing(input int idle_pct, input int stall_pct, input int goal);
        int start;
        int kind;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                send_byte(ASCII_ESC, 1'b1);
                send_byte(ASCII_LBRACKET, 1'($urandom_range(0, 1)));
                send_byte(8'(8'h41 + $urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
            else if (kind < 60)
            begin
                send_byte(8'($urandom_range(8'h20, 8'h7e)), 1'($urandom_range(0, 1)));
            end
            else if (kind < 72)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else if (kind < 80)
            begin
                send_byte(ASCII_ESC, 1'b0);
            end
            else if (kind < 90)
            begin
                send_byte(ASCII_ESC, 1'b1);
                len = $urandom_range(1, 9);
                repeat (len)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                send_byte(ASCII_ESC, 1'b1);
                send_byte(ASCII_LBRACKET, 1'b1);
                len = $urandom_range(1, 7);
                repeat (len)
                begin
                    send_byte(8'($urandom_range(8'h40, 8'h5f)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        byte_if.valid           = 1'b0;
        byte_if.char_byte       = 8'h00;
        byte_if.next_is_bracket = 1'b0;
        report_if.ready         = 1'b0;
        esc_held                = 0;
        esc_seq                 = '{default: 8'h00};
        down_keys               = '{default: 8'h00};
        down_count              = 0;
        shift_mods              = 8'h00;
        mismatch_count          = 0;
        items_sent              = 0;
        send_idle_pct           = 27;
        recv_stall_pct          = 54;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_keys();
        test_escape_handling();
        test_random_typing(27, 54, 440);
        test_random_typing(54, 27, 440);
        test_random_typing(0, 0, 440);

        byte_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ahk_pkg.sv
sv/ahk_channels.sv
sv/ahk_front.sv
sv/ahk_queue.sv
sv/ahk_back.sv
sv/ascii_to_hid_keyboard_report.sv
sim/ascii_to_hid_keyboard_report_test.sv
